FILE: src/sml_pkg.sv
// ----------------------------------------------------------------------------
// sml_pkg
// shared constants and types of the sparse map nearest lookup unit
// ----------------------------------------------------------------------------
package sml_pkg;

    localparam int unsigned N_ENTRIES = 2048;
    localparam int unsigned AW        = 11;
    localparam int unsigned DW        = 32;
    localparam int unsigned CW        = AW + 1;

    typedef enum logic [2:0] {
        MODE_QUERY  = 3'd0,
        MODE_SET    = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_SHUNT  = 3'd3,
        MODE_SHIFT  = 3'd4,
        MODE_INSERT = 3'd5,
        MODE_CLEAR  = 3'd6,
        MODE_NONE   = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        POL_BLOCK   = 2'd0,
        POL_NEAREST = 2'd1,
        POL_UP      = 2'd2,
        POL_DOWN    = 2'd3
    } t_policy;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QRD,
        ST_QCHK,
        ST_SADDR,
        ST_SCHK,
        ST_SET,
        ST_RRD,
        ST_RWR,
        ST_RCLR,
        ST_ORD,
        ST_OWR,
        ST_OFIN
    } t_state;

endpackage

FILE: src/sparse_map_nearest_lookup_unit.sv
// ----------------------------------------------------------------------------
// sparse_map_nearest_lookup_unit
// sparse table of signed values with exact and nearest-present lookup and
// in-place edits (set, delete, shunt, shift, insert, clear)
// ----------------------------------------------------------------------------
// query: a hit is read and then checked; a search probes one entry at a time in an
//   address state and a check state, for nearest on an empty table both sides of every distance
// edits: set writes one entry; delete/shunt/shift/insert read and write each moved
//   entry in turn, then finish; clear zeroes every entry; one item at a time
// reset: control clears synchronously, then a clearing pass that zeroes every entry keeps
//   busy high; results are a one-cycle strobe and the receiver cannot stall
module sparse_map_nearest_lookup_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_mode,
    input  logic [sml_pkg::AW-1:0]        i_index,
    input  logic signed [sml_pkg::DW-1:0] i_new_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_data,
    output logic                          o_valid,
    output logic [sml_pkg::AW-1:0]        o_found_index,
    output logic signed [sml_pkg::DW-1:0] o_map_value,
    output logic                          o_exact_hit
);
    import sml_pkg::*;

    // entry storage, one read and one write port
    logic [DW-1:0] mem [N_ENTRIES];
    logic [DW-1:0] r_rdata;

    t_state        r_state, n_state;
    t_mode         r_mode;
    logic [AW-1:0] r_idx;
    logic [DW-1:0] r_val;
    logic [AW-1:0] r_hi, n_hi;
    logic [1:0]    r_pol;
    logic [CW-1:0] r_k, n_k;
    logic          r_side, n_side;
    logic          r_bz, n_bz;

    logic          r_ov, n_ov;
    logic [AW-1:0] r_of, n_of;
    logic [DW-1:0] r_ovl, n_ovl;
    logic          r_ox, n_ox;

    logic          rd_en, we;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [DW-1:0] wr_data;

    logic          accept;
    logic [CW-1:0] top_in, sum, diff;
    logic [AW-1:0] cand_addr;
    logic          cand_ok, last;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_valid       = r_ov;
    assign o_found_index = r_of;
    assign o_map_value   = r_ovl;
    assign o_exact_hit   = r_ox;

    // search candidate: distance r_k above or below the queried index
    assign top_in = {1'b0, r_hi} + CW'(1);
    assign sum    = {1'b0, r_idx} + r_k;
    assign diff   = {1'b0, r_idx} - r_k;
    always_comb begin
        case (t_policy'(r_pol))
            POL_NEAREST: begin
                cand_ok   = r_side ? ({1'b0, r_idx} >= r_k) : (sum < CW'(N_ENTRIES));
                cand_addr = r_side ? diff[AW-1:0] : sum[AW-1:0];
            end
            POL_DOWN: begin
                cand_ok   = 1'b1;
                cand_addr = diff[AW-1:0];
            end
            default: begin
                cand_ok   = 1'b1;
                cand_addr = sum[AW-1:0];
            end
        endcase
    end
    // last probe: largest distance, and for nearest the lower side too
    assign last = (r_k == CW'(N_ENTRIES - 1))
               && ((t_policy'(r_pol) != POL_NEAREST) || r_side);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_k == CW'(N_ENTRIES - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    case (t_mode'(i_mode)) inside
                        MODE_QUERY: n_state = ST_QRD;
                        MODE_SET:   n_state = ST_SET;
                        MODE_DELETE, MODE_SHUNT: begin
                            if (i_index < r_hi)       n_state = ST_RRD;
                            else if (i_index == r_hi) n_state = ST_RCLR;
                        end
                        MODE_SHIFT, MODE_INSERT: begin
                            if (top_in < CW'(N_ENTRIES)) begin
                                if ({1'b0, i_index} > top_in) n_state = ST_OFIN;
                                else                          n_state = ST_ORD;
                            end
                        end
                        MODE_CLEAR: n_state = ST_CLEAR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_QRD:  n_state = ST_QCHK;
            ST_QCHK: begin
                if (r_rdata != '0 || t_policy'(r_pol) == POL_BLOCK) n_state = ST_IDLE;
                else                                                n_state = ST_SADDR;
            end
            ST_SADDR: begin
                if (cand_ok)   n_state = ST_SCHK;
                else if (last) n_state = ST_IDLE;
            end
            ST_SCHK: begin
                if (r_rdata != '0 || last) n_state = ST_IDLE;
                else                       n_state = ST_SADDR;
            end
            ST_SET:  n_state = ST_IDLE;
            ST_RRD:  n_state = ST_RWR;
            ST_RWR:  n_state = (r_k == {1'b0, r_hi}) ? ST_RCLR : ST_RRD;
            ST_RCLR: n_state = ST_IDLE;
            ST_ORD:  n_state = ST_OWR;
            ST_OWR:  n_state = (r_k == {1'b0, r_idx}) ? ST_OFIN : ST_ORD;
            ST_OFIN: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath, memory control and result
    always_comb begin
        n_hi    = r_hi;
        n_k     = r_k;
        n_side  = r_side;
        n_bz    = r_bz;
        n_ov    = 1'b0;
        n_of    = r_of;
        n_ovl   = r_ovl;
        n_ox    = r_ox;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        we      = 1'b0;
        wr_addr = r_idx;
        wr_data = r_val;
        unique case (r_state)
            ST_CLEAR: begin
                we      = 1'b1;
                wr_addr = r_k[AW-1:0];
                wr_data = '0;
                n_k     = r_k + CW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    case (t_mode'(i_mode)) inside
                        MODE_DELETE, MODE_SHUNT: n_k = {1'b0, i_index} + CW'(1);
                        MODE_SHIFT, MODE_INSERT: n_k = top_in;
                        MODE_CLEAR: begin
                            n_k  = '0;
                            n_hi = '0;
                        end
                        default: n_k = r_k;
                    endcase
                end
            end
            ST_QRD: rd_en = 1'b1;
            ST_QCHK: begin
                if (r_rdata != '0) begin
                    n_ov  = 1'b1;
                    n_of  = r_idx;
                    n_ovl = r_rdata;
                    n_ox  = 1'b1;
                end
                n_k    = CW'(1);
                n_side = 1'b0;
            end
            ST_SADDR: begin
                rd_addr = cand_addr;
                if (cand_ok) begin
                    rd_en = 1'b1;
                end else if (t_policy'(r_pol) == POL_NEAREST && !r_side) begin
                    n_side = 1'b1;
                end else begin
                    n_side = 1'b0;
                    n_k    = r_k + CW'(1);
                end
            end
            ST_SCHK: begin
                if (r_rdata != '0) begin
                    n_ov  = 1'b1;
                    n_of  = cand_addr;
                    n_ovl = r_rdata;
                    n_ox  = 1'b0;
                end else if (t_policy'(r_pol) == POL_NEAREST && !r_side) begin
                    n_side = 1'b1;
                end else begin
                    n_side = 1'b0;
                    n_k    = r_k + CW'(1);
                end
            end
            ST_SET: begin
                we = 1'b1;
                if (r_idx > r_hi) n_hi = r_idx;
            end
            ST_RRD: begin
                rd_en   = 1'b1;
                rd_addr = r_k[AW-1:0];
            end
            ST_RWR: begin
                // move one entry down, shunt also subtracts one
                we      = 1'b1;
                wr_addr = r_k[AW-1:0] - AW'(1);
                wr_data = r_rdata - ((r_mode == MODE_SHUNT) ? DW'(1) : DW'(0));
                n_k     = r_k + CW'(1);
            end
            ST_RCLR: begin
                we      = 1'b1;
                wr_addr = r_hi;
                wr_data = '0;
                if (r_hi != '0) n_hi = r_hi - AW'(1);
            end
            ST_ORD: begin
                // entry below index zero reads as zero
                rd_en   = (r_k != '0);
                rd_addr = r_k[AW-1:0] - AW'(1);
                n_bz    = (r_k == '0);
            end
            ST_OWR: begin
                we      = 1'b1;
                wr_addr = r_k[AW-1:0];
                wr_data = (r_bz ? '0 : r_rdata)
                        + ((r_mode == MODE_SHIFT) ? DW'(1) : DW'(0));
                n_k     = r_k - CW'(1);
            end
            ST_OFIN: begin
                we   = (r_mode == MODE_INSERT);
                n_hi = r_hi + AW'(1);
            end
            default: ;
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
            r_hi    <= '0;
            r_pol   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_hi    <= n_hi;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) r_pol <= i_cfg_data;
        end
    end

    // payload capture at the input transfer, and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_mode);
            r_idx  <= i_index;
            r_val  <= i_new_value;
        end
        r_side <= n_side;
        r_bz   <= n_bz;
        r_of   <= n_of;
        r_ovl  <= n_ovl;
        r_ox   <= n_ox;
    end

endmodule

FILE: src/sml_checker.sv
// ----------------------------------------------------------------------------
// sml_checker
// port-level checks of the sparse map nearest lookup unit
// ----------------------------------------------------------------------------
module sml_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_valid,
    input logic o_exact_hit
);

    // a result ends the work of its item
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // one strobe per result
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");

    // reset starts the clearing pass
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("no clearing pass after reset");

    // an exact hit is never quicker than a read and a check
    a_exact_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_exact_hit) |-> $past(busy, 2)) else $error("hit too early");

endmodule

bind sparse_map_nearest_lookup_unit sml_checker u_sml_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_exact_hit (o_exact_hit)
);
